>>> src/lpvu_pkg.sv
// ----------------------------------------------------------------------------
// lpvu_pkg: shared types and constants for the label propagation vertex update
// Beat layouts of the item and result channels, field widths, the count
// saturation limit and the tie-breaking LFSR step.
// ----------------------------------------------------------------------------
package lpvu_pkg;

  localparam int LABEL_W = 10;
  localparam int COUNT_W = 7;
  localparam int LFSR_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
  localparam logic [LFSR_W-1:0]  LFSR_MASK = 16'hB400;

  localparam int DEF_NUM_VERTICES = 1024;
  localparam int DEF_MAX_DEGREE   = 64;

  // Item kinds.
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [LABEL_W-1:0] vertex;
    logic [LABEL_W-1:0] neighbour;
    logic               last_edge;
  } in_item_t;

  typedef struct packed {
    logic [LABEL_W-1:0] out_vertex;
    logic [LABEL_W-1:0] out_label;
    logic               changed;
    logic               is_update;
  } out_item_t;

  // One step of the right-shifting Galois LFSR. A zero state is treated as one.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] v;
    v = (s == '0) ? LFSR_W'(1) : s;
    if (v[0]) begin
      lfsr_step = (v >> 1) ^ LFSR_MASK;
    end else begin
      lfsr_step = v >> 1;
    end
  endfunction

endpackage

>>> src/label_propagation_vertex_update.sv
// Steps: a read beat passes S_RD, then S_OUT posts its result; a buffered
// edge beat passes S_E1 and S_E2 and returns to S_IDLE. A last edge adds S_L0,
// S_OWN, a walk of S_W0, S_W1, S_W2 per buffered label and S_DEC; if the own
// label is not among the most frequent, S_DIV (serial remainder), S_TR and S_TD
// follow; then S_WB and S_OUT write back and post the result. One item at a
// time. Reset: a clearing pass writes the label and count memories first.
// ----------------------------------------------------------------------------
// label_propagation_vertex_update
// One step of asynchronous label propagation for a vertex: neighbour labels
// are counted in a count memory, the most frequent ones are listed and one is
// chosen, and the vertex label is written back. Read beats return a label.
// ----------------------------------------------------------------------------
module label_propagation_vertex_update
  import lpvu_pkg::*;
#(
  parameter int NUM_VERTICES = DEF_NUM_VERTICES,
  parameter int MAX_DEGREE   = DEF_MAX_DEGREE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LFSR_W-1:0] cfg_data
);

  // Only vertex numbers that fit the 10-bit fields can ever be addressed, so
  // the stores hold at most 1024 entries.
  localparam int VD  = (NUM_VERTICES < (1 << LABEL_W)) ? NUM_VERTICES : (1 << LABEL_W);
  localparam int AW  = (VD > 1) ? $clog2(VD) : 1;
  localparam int ECW = $clog2(MAX_DEGREE + 1);
  localparam int IW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  // Sequencer states.
  localparam logic [3:0] S_CLR  = 4'd0;   // clearing pass after reset
  localparam logic [3:0] S_IDLE = 4'd1;   // waiting for a beat
  localparam logic [3:0] S_RD   = 4'd2;   // read data of a label read
  localparam logic [3:0] S_E1   = 4'd3;   // neighbour label back, fetch its count
  localparam logic [3:0] S_E2   = 4'd4;   // count back, write incremented count
  localparam logic [3:0] S_L0   = 4'd5;   // last edge seen, fetch own label
  localparam logic [3:0] S_OWN  = 4'd6;   // capture own label
  localparam logic [3:0] S_W0   = 4'd7;   // walk: read buffered label
  localparam logic [3:0] S_W1   = 4'd8;   // walk: read its count
  localparam logic [3:0] S_W2   = 4'd9;   // walk: list ties, clear count
  localparam logic [3:0] S_DEC  = 4'd10;  // decide keep or random pick
  localparam logic [3:0] S_DIV  = 4'd11;  // serial remainder of LFSR by tie count
  localparam logic [3:0] S_TR   = 4'd12;  // read chosen tie entry
  localparam logic [3:0] S_TD   = 4'd13;  // capture chosen label
  localparam logic [3:0] S_WB   = 4'd14;  // write the new label back
  localparam logic [3:0] S_OUT  = 4'd15;  // post the result beat

  logic [3:0]         state;
  logic [AW-1:0]      clr_idx;
  logic [ECW-1:0]     edge_count;
  logic [ECW-1:0]     walk_idx;
  logic [ECW-1:0]     nties;
  logic [COUNT_W-1:0] best;
  logic [LABEL_W-1:0] cur_vertex;
  logic               last_q;
  logic [LABEL_W-1:0] lab_q;
  logic [LABEL_W-1:0] own;
  logic [LABEL_W-1:0] newlab;
  logic               keep;
  logic [LFSR_W-1:0]  lfsr;
  logic [LFSR_W-1:0]  dividend;
  logic [ECW:0]       rem;
  logic [3:0]         div_cnt;
  out_item_t          res_item;

  // Label memory: one write port, one registered read port.
  logic [LABEL_W-1:0] label_mem [VD];
  logic [AW-1:0]      label_raddr, label_waddr;
  logic [LABEL_W-1:0] label_wdata, label_rdata;
  logic               label_we;

  // Count memory.
  logic [COUNT_W-1:0] cnt_mem [VD];
  logic [AW-1:0]      cnt_raddr, cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;
  logic               cnt_we;

  // Neighbour label buffer and tie list.
  logic [LABEL_W-1:0] buf_mem [MAX_DEGREE];
  logic [LABEL_W-1:0] buf_rdata;
  logic [LABEL_W-1:0] tie_mem [MAX_DEGREE];
  logic [LABEL_W-1:0] tie_rdata;

  logic               in_acc;
  logic               edge_ok;
  logic               vin;
  logic [COUNT_W-1:0] cnt_inc;
  logic [ECW:0]       trial;
  logic [LFSR_W-1:0]  lfsr_n;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  // An edge is buffered only while there is room and its neighbour exists.
  assign edge_ok = (edge_count < ECW'(MAX_DEGREE)) &&
                   (32'(in_item.neighbour) < NUM_VERTICES);
  assign vin     = 32'(cur_vertex) < NUM_VERTICES;

  // The count saturates at its maximum.
  assign cnt_inc = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + COUNT_W'(1);

  // Restoring remainder step: bring down the next dividend bit.
  assign trial  = {rem[ECW-1:0], dividend[LFSR_W-1]};
  assign lfsr_n = lfsr_step(lfsr);

  // Read address selection for the label memory: the addressed item in IDLE,
  // otherwise the vertex being updated.
  always_comb begin
    if (state == S_IDLE) begin
      label_raddr = (in_item.kind == KIND_READ) ? in_item.vertex[AW-1:0]
                                                : in_item.neighbour[AW-1:0];
    end else begin
      label_raddr = cur_vertex[AW-1:0];
    end
  end

  always_comb begin
    if (state == S_W1) begin
      cnt_raddr = buf_rdata[AW-1:0];
    end else begin
      cnt_raddr = label_rdata[AW-1:0];
    end
  end

  // Write ports. The clearing pass restores the reset contents; afterwards
  // counts are zeroed again by every walk, so they stay clear between vertices.
  always_comb begin
    label_we    = 1'b0;
    label_waddr = cur_vertex[AW-1:0];
    label_wdata = newlab;
    cnt_we      = 1'b0;
    cnt_waddr   = lab_q[AW-1:0];
    cnt_wdata   = '0;
    case (state)
      S_CLR: begin
        label_we    = 1'b1;
        label_waddr = clr_idx;
        label_wdata = LABEL_W'(clr_idx);
        cnt_we      = 1'b1;
        cnt_waddr   = clr_idx;
      end
      S_E2: begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_inc;
      end
      S_W2: begin
        cnt_we = 1'b1;
      end
      S_WB: begin
        label_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (label_we) begin
      label_mem[label_waddr] <= label_wdata;
    end
    label_rdata <= label_mem[label_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_E1) begin
      buf_mem[edge_count[IW-1:0]] <= label_rdata;
    end
    buf_rdata <= buf_mem[walk_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if ((state == S_W2) && (cnt_rdata == best)) begin
      tie_mem[nties[IW-1:0]] <= lab_q;
    end
    tie_rdata <= tie_mem[rem[IW-1:0]];
  end

  // Main sequencer. During the edge stream the running maximum of the counts
  // is kept, so the walk needs one pass: a label joins the tie list when its
  // count equals the maximum, and its count is cleared at once, so a later
  // copy of the same label reads zero and is not listed twice.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_idx    <= '0;
      edge_count <= '0;
      walk_idx   <= '0;
      nties      <= '0;
      best       <= '0;
      keep       <= 1'b0;
      lfsr       <= LFSR_W'(1);
      out_valid  <= 1'b0;
    end else begin
      // In S_OUT the result register is reloaded below instead.
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + AW'(1);
          if (32'(clr_idx) == VD - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            cur_vertex <= in_item.vertex;
            last_q     <= in_item.last_edge;
            if (in_item.kind == KIND_READ) begin
              state <= S_RD;
            end else if (edge_ok) begin
              state <= S_E1;
            end else if (in_item.last_edge) begin
              state <= S_L0;
            end
          end
        end
        S_RD: begin
          res_item.out_vertex <= cur_vertex;
          res_item.out_label  <= vin ? label_rdata : '0;
          res_item.changed    <= 1'b0;
          res_item.is_update  <= 1'b0;
          state               <= S_OUT;
        end
        S_E1: begin
          lab_q <= label_rdata;
          state <= S_E2;
        end
        S_E2: begin
          if (cnt_inc > best) begin
            best <= cnt_inc;
          end
          edge_count <= edge_count + ECW'(1);
          state      <= last_q ? S_L0 : S_IDLE;
        end
        S_L0: begin
          walk_idx <= '0;
          nties    <= '0;
          keep     <= 1'b0;
          state    <= (edge_count == '0) ? S_IDLE : S_OWN;
        end
        S_OWN: begin
          own   <= label_rdata;
          state <= S_W0;
        end
        S_W0: begin
          state <= S_W1;
        end
        S_W1: begin
          lab_q <= buf_rdata;
          state <= S_W2;
        end
        S_W2: begin
          if (cnt_rdata == best) begin
            nties <= nties + ECW'(1);
            if (lab_q == own) begin
              keep <= 1'b1;
            end
          end
          if (walk_idx + ECW'(1) == edge_count) begin
            state <= S_DEC;
          end else begin
            walk_idx <= walk_idx + ECW'(1);
            state    <= S_W0;
          end
        end
        S_DEC: begin
          edge_count <= '0;
          best       <= '0;
          if (!vin) begin
            state <= S_IDLE;
          end else if (keep) begin
            newlab <= own;
            state  <= S_WB;
          end else begin
            if (!(cfg_valid && cfg_ready)) begin
              lfsr <= lfsr_n;
            end
            dividend <= lfsr_n;
            rem      <= '0;
            div_cnt  <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (trial >= {1'b0, nties}) begin
            rem <= trial - {1'b0, nties};
          end else begin
            rem <= trial;
          end
          dividend <= dividend << 1;
          div_cnt  <= div_cnt + 4'd1;
          if (div_cnt == 4'(LFSR_W - 1)) begin
            state <= S_TR;
          end
        end
        S_TR: begin
          state <= S_TD;
        end
        S_TD: begin
          newlab <= tie_rdata;
          state  <= S_WB;
        end
        S_WB: begin
          res_item.out_vertex <= cur_vertex;
          res_item.out_label  <= newlab;
          res_item.changed    <= (newlab != own);
          res_item.is_update  <= 1'b1;
          state               <= S_OUT;
        end
        S_OUT: begin
          // The result register is free or is being emptied this cycle.
          if (!out_valid || out_ready) begin
            out_item  <= res_item;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // A seed write reloads the LFSR at once; zero is loaded as one.
      if (cfg_valid && cfg_ready) begin
        lfsr <= (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    edge_count <= ECW'(MAX_DEGREE))
    else $error("edge count beyond maximum degree");

  a_ties_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC) |-> (nties != '0) && (nties <= edge_count))
    else $error("tie list empty or longer than the buffered edges");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TR) |-> (rem < {1'b0, nties}))
    else $error("tie index not below tie count");

  a_keep_own: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) && keep |-> (newlab == own))
    else $error("kept label differs from own label");
`endif

endmodule

>>> tb/sv/label_propagation_vertex_update_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// label_propagation_vertex_update_test: self-checking bench for the vertex update
// Drives edge streams and label reads over the item channel and predicts every
// result with a behavioral label store, count store and tie-breaking LFSR.
// Results are compared field by field in order through a small scoreboard.
// ----------------------------------------------------------------------------
module label_propagation_vertex_update_test;
  import lpvu_pkg::*;

  localparam int NV = 1024;
  localparam int MD = 64;
  localparam int STALL_LIMIT = 20000;

  // Behavioral copy of the block: labels, counts, buffered labels and LFSR.
  class label_scoreboard;
    logic [LABEL_W-1:0] labels [NV];
    logic [COUNT_W-1:0] counts [NV];
    logic [LABEL_W-1:0] buffered [MD];
    logic [LABEL_W-1:0] ties [MD];
    int unsigned        edges;
    logic [LFSR_W-1:0]  lfsr;
    out_item_t          pending [$];
    int unsigned        mismatches;

    function void reset_state();
      for (int i = 0; i < NV; i++) begin
        labels[i] = LABEL_W'(i);
        counts[i] = '0;
      end
      edges = 0;
      lfsr = 16'd1;
      pending.delete();
      mismatches = 0;
    endfunction

    function void load_seed(logic [LFSR_W-1:0] s);
      lfsr = (s == '0) ? 16'd1 : s;
    endfunction

    function logic [LFSR_W-1:0] advance_lfsr();
      logic [LFSR_W-1:0] v;
      v = (lfsr == '0) ? 16'd1 : lfsr;
      v = v[0] ? ((v >> 1) ^ 16'hB400) : (v >> 1);
      lfsr = v;
      return v;
    endfunction

    function void clear_counts();
      for (int i = 0; i < edges && i < MD; i++) counts[buffered[i]] = '0;
    endfunction

    // Note one accepted item and queue the result it causes, if any.
    function void note_item(in_item_t it);
      out_item_t r;
      int unsigned best, nties, c;
      bit seen, keep;
      logic [LABEL_W-1:0] own, lab, nl;
      if (it.kind == KIND_READ) begin
        r.out_vertex = it.vertex;
        r.out_label = labels[it.vertex];
        r.changed = 1'b0;
        r.is_update = 1'b0;
        pending.push_back(r);
        return;
      end
      if (edges < MD) begin
        lab = labels[it.neighbour];
        buffered[edges] = lab;
        if (counts[lab] < COUNT_MAX) counts[lab] = counts[lab] + 1'b1;
        edges++;
      end
      if (!it.last_edge || edges == 0) return;
      best = 0;
      nties = 0;
      for (int i = 0; i < edges; i++) begin
        lab = buffered[i];
        c = 32'(counts[lab]);
        if (c > best) begin
          best = c;
          ties[0] = lab;
          nties = 1;
        end else if (c == best) begin
          seen = 0;
          for (int j = 0; j < nties; j++) if (ties[j] == lab) seen = 1;
          if (!seen && nties < MD) begin
            ties[nties] = lab;
            nties++;
          end
        end
      end
      own = labels[it.vertex];
      keep = 0;
      for (int j = 0; j < nties; j++) if (ties[j] == own) keep = 1;
      if (keep || nties == 0) nl = own;
      else nl = ties[advance_lfsr() % nties];
      clear_counts();
      edges = 0;
      labels[it.vertex] = nl;
      r.out_vertex = it.vertex;
      r.out_label = nl;
      r.changed = (nl != own);
      r.is_update = 1'b1;
      pending.push_back(r);
    endfunction

    // Compare one result beat with the oldest expected result.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.out_vertex !== want.out_vertex || got.out_label !== want.out_label ||
          got.changed !== want.changed || got.is_update !== want.is_update) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [LFSR_W-1:0] cfg_data = '0;

  label_propagation_vertex_update i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  label_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  bit timed_out = 0;

  // Results are sampled at the rising edge; ready moves at the falling edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_item);
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: cycles in a row with no beat on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("** label_propagation_vertex_update: FAILED **");
        $finish;
      end
    end
  end

  // Send one item beat, with a random idle gap in front of it. Valid stays
  // high after the beat until the next beat or an idle cycle replaces it.
  task automatic send_item(logic kind, int v, int nb, logic last);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    it.kind = kind;
    it.vertex = LABEL_W'(v);
    it.neighbour = LABEL_W'(nb);
    it.last_edge = last;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_item(it);
    @(negedge clk);
  endtask

  // Wait for every expected result, then for the walk of any skipped update.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic write_seed(logic [LFSR_W-1:0] s);
    cfg_data <= s;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.load_seed(s);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A vertex's out-edges; neighbours drawn from a small pool so labels tie.
  task automatic send_vertex(int v, int deg, int pool);
    for (int i = 0; i < deg; i++) begin
      if ($urandom_range(19) == 0) send_item(KIND_READ, $urandom_range(1023), 0, 1'b0);
      send_item(KIND_EDGE, (i == deg - 1) ? v : $urandom_range(1023),
                $urandom_range(pool), i == deg - 1);
    end
  endtask

  task automatic random_phase(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(9))
        0: begin
          send_item(KIND_READ, $urandom_range(1023), $urandom_range(1023),
                    1'($urandom_range(1)));
          sent++;
        end
        1: begin
          send_item(KIND_EDGE, $urandom_range(1023), $urandom_range(1023),
                    1'($urandom_range(1)));
          sent++;
        end
        default: begin
          int deg;
          deg = ($urandom_range(29) == 0) ? $urandom_range(70, 64) : $urandom_range(1, 8);
          send_vertex($urandom_range(15), deg, $urandom_range(1, 20));
          sent += deg;
        end
      endcase
    end
  endtask

  initial begin
    board.reset_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: reads at both ends, a single-edge vertex, edges past the
    // maximum degree, and a zero seed.
    send_item(KIND_READ, 0, 1023, 1'b1);
    send_item(KIND_READ, 1023, 0, 1'b0);
    send_item(KIND_EDGE, 1023, 0, 1'b1);
    send_item(KIND_EDGE, 5, 1023, 1'b0);
    send_item(KIND_EDGE, 5, 7, 1'b0);
    send_item(KIND_EDGE, 5, 9, 1'b1);
    send_item(KIND_READ, 5, 0, 1'b0);
    send_item(KIND_READ, 1023, 0, 1'b0);
    drain();
    write_seed(16'h0000);
    for (int i = 0; i < 66; i++) send_item(KIND_EDGE, 3, i % 3 + 100, i == 65);
    drain();
    write_seed(16'hFFFF);
    send_vertex(2, 5, 3);
    drain();

    send_idle_pct = 21;
    recv_idle_pct = 54;
    random_phase(240);
    drain();
    write_seed(16'($urandom_range(65535, 1)));
    send_idle_pct = 54;
    recv_idle_pct = 21;
    random_phase(240);
    drain();
    write_seed(16'h0001);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(240);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("** label_propagation_vertex_update: PASSED **");
    end else begin
      $display("** label_propagation_vertex_update: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lpvu_pkg.sv
src/label_propagation_vertex_update.sv
tb/sv/label_propagation_vertex_update_test.sv
